>>> rtl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg: shared constants and helpers for the great-circle distance core
// Fixed-point formats, radian conversion factor, CORDIC angle table and the
// Q30 product rounding used by the pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

	localparam int CORDIC_STAGES_DEF = 24;

	// angle after radian conversion, CORDIC datapath, raw product widths
	localparam int ANG_W  = 35;
	localparam int XY_W   = 34;
	localparam int PROD_W = 2 * XY_W;

	// degree to radian factor, Q34: round(314159 * 2^34 / 18000000)
	localparam logic [63:0] RAD_FACTOR_64 = ((64'd314159 << 34) + 64'd9000000) / 64'd18000000;
	localparam logic [28:0] RAD_FACTOR    = RAD_FACTOR_64[28:0];

	localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
	localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;
	localparam logic [30:0]             ONE_Q30     = 31'h4000_0000;
	localparam logic [31:0]             SCALE_RESET = 32'd250734182;

	// atan(2^-idx) in Q30, rounded to nearest
	function automatic logic signed [XY_W-1:0] atan_q30(input int idx);
		logic signed [XY_W-1:0] r;
		case (idx)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			default: begin
				if (idx <= 30)
					r = $signed(34'd1 << (30 - idx));
				else if (idx == 31)
					r = 34'sd1;
				else
					r = 34'sd0;
			end
		endcase
		return r;
	endfunction

	// Q60 product back to Q30, rounded half away from zero
	function automatic logic signed [XY_W-1:0] rnd_q30(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] r;
		mag = p[PROD_W-1] ? $unsigned(-p) : $unsigned(p);
		r   = (mag + PROD_W'(64'd536870912)) >> 30;
		return p[PROD_W-1] ? -$signed(r[XY_W-1:0]) : $signed(r[XY_W-1:0]);
	endfunction

endpackage

>>> rtl/great_circle_distance_core.sv
// ----------------------------------------------------------------------------
// Throughput: one point pair per cycle; the whole pipeline holds when the
// output beat is not taken.
// Depth comes from the rotation and vectoring CORDIC stages and the 31-stage
// square roots. Reset clears all valid bits and reloads the distance scale.
// ----------------------------------------------------------------------------
// great_circle_distance_core: haversine great-circle distance
// Degrees to radians, haversine term, central angle by atan2 of square roots,
// scaled to an unsigned Q16.16 distance with saturation.
// ----------------------------------------------------------------------------
module great_circle_distance_core #(
	parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [29:0] first_latitude,
	input  logic signed [30:0] first_longitude,
	input  logic signed [29:0] second_latitude,
	input  logic signed [30:0] second_longitude,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        distance
);

	localparam int LAT    = 2 * CORDIC_STAGES + 43;
	localparam int ANG_W  = gcd_pkg::ANG_W;
	localparam int XY_W   = gcd_pkg::XY_W;
	localparam int PROD_W = gcd_pkg::PROD_W;

	logic             adv;
	logic [LAT-1:0]   vld_q;
	logic [31:0]      distance_scale_q;

	logic signed [32:0] dval [0:3];
	logic [31:0]        mag_s1 [0:3];
	logic               neg_s1 [0:3];
	logic [60:0]        prod_s2 [0:3];
	logic               neg_s2 [0:3];
	logic signed [ANG_W-1:0] ang_s3 [0:3];

	logic signed [XY_W-1:0] sin_v [0:1];
	logic signed [XY_W-1:0] cos_v [0:1];

	logic signed [PROD_W-1:0] sqlat_s4, sqlon_s4, cc_s4;
	logic signed [XY_W-1:0]   slat2_s5, slon2_s5, cc_s5;
	logic signed [PROD_W-1:0] p2_s6;
	logic signed [XY_W-1:0]   slat2_s6;
	logic signed [XY_W-1:0]   t_s7, slat2_s7;
	logic signed [XY_W:0]     hsum;
	logic [30:0]              h_s8;
	logic [30:0]              root_y, root_x;

	logic signed [XY_W-1:0] vx_s [1:CORDIC_STAGES];
	logic signed [XY_W-1:0] vy_s [1:CORDIC_STAGES];
	logic signed [XY_W-1:0] vz_s [1:CORDIC_STAGES];

	logic [XY_W:0]  twice;
	logic [31:0]    central;
	logic [63:0]    prod_s9;
	logic [64:0]    dsum;
	logic [34:0]    dq;
	logic [31:0]    dist_s10;

	// advance the whole pipeline unless the output beat is stalled
	assign adv       = !vld_q[LAT-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[LAT-1];
	assign distance  = dist_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			distance_scale_q <= gcd_pkg::SCALE_RESET;
		else if (cfg_wr_en)
			distance_scale_q <= cfg_wr_data;
	end

	// half differences and latitudes, as sign and magnitude
	assign dval[0] = 33'(second_latitude) - 33'(first_latitude);
	assign dval[1] = 33'(second_longitude) - 33'(first_longitude);
	assign dval[2] = 33'(first_latitude);
	assign dval[3] = 33'(second_latitude);

	for (genvar k = 0; k < 4; k++) begin : g_rad
		localparam int SH = (k < 2) ? 27 : 26;
		logic [61:0]      rsum;
		logic [ANG_W-1:0] rmag;

		always_ff @(posedge clk) begin
			if (adv) begin
				mag_s1[k]  <= dval[k][32] ? 32'($unsigned(-dval[k])) : 32'($unsigned(dval[k]));
				neg_s1[k]  <= dval[k][32];
				prod_s2[k] <= 61'(mag_s1[k]) * 61'(gcd_pkg::RAD_FACTOR);
				neg_s2[k]  <= neg_s1[k];
				ang_s3[k]  <= neg_s2[k] ? -$signed(rmag) : $signed(rmag);
			end
		end

		// round to Q30 radians, half away from zero
		assign rsum = 62'(prod_s2[k]) + (62'd1 << (SH - 1));
		assign rmag = ANG_W'(rsum >> SH);
	end

	// sines of the half differences
	for (genvar k = 0; k < 2; k++) begin : g_sin
		gcd_sincos #(.STAGES(CORDIC_STAGES)) u_sincos (
			.clk     (clk),
			.en      (adv),
			.ang     (ang_s3[k]),
			.sin_val (sin_v[k]),
			.cos_val ()
		);
	end

	// cosines of the latitudes
	for (genvar k = 0; k < 2; k++) begin : g_cos
		gcd_sincos #(.STAGES(CORDIC_STAGES)) u_sincos (
			.clk     (clk),
			.en      (adv),
			.ang     (ang_s3[k+2]),
			.sin_val (),
			.cos_val (cos_v[k])
		);
	end

	// haversine term
	always_ff @(posedge clk) begin
		if (adv) begin
			sqlat_s4 <= sin_v[0] * sin_v[0];
			sqlon_s4 <= sin_v[1] * sin_v[1];
			cc_s4    <= cos_v[0] * cos_v[1];
			slat2_s5 <= gcd_pkg::rnd_q30(sqlat_s4);
			slon2_s5 <= gcd_pkg::rnd_q30(sqlon_s4);
			cc_s5    <= gcd_pkg::rnd_q30(cc_s4);
			p2_s6    <= cc_s5 * slon2_s5;
			slat2_s6 <= slat2_s5;
			t_s7     <= gcd_pkg::rnd_q30(p2_s6);
			slat2_s7 <= slat2_s6;
		end
	end

	// clamp the term to [0, 1]
	assign hsum = (XY_W+1)'(slat2_s7) + (XY_W+1)'(t_s7);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (hsum[XY_W])
				h_s8 <= '0;
			else if (hsum > (XY_W+1)'(gcd_pkg::ONE_Q30))
				h_s8 <= gcd_pkg::ONE_Q30;
			else
				h_s8 <= hsum[30:0];
		end
	end

	gcd_isqrt u_sqrt_h (
		.clk      (clk),
		.en       (adv),
		.radicand (62'({h_s8, 30'd0})),
		.root     (root_y)
	);

	gcd_isqrt u_sqrt_c (
		.clk      (clk),
		.en       (adv),
		.radicand (62'({gcd_pkg::ONE_Q30 - h_s8, 30'd0})),
		.root     (root_x)
	);

	// vectoring CORDIC for the central half angle
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		localparam logic signed [XY_W-1:0] ATAN_I = gcd_pkg::atan_q30(i);
		logic signed [XY_W-1:0] x_in, y_in, z_in;

		if (i == 0) begin : g_first
			assign x_in = $signed(XY_W'(root_x));
			assign y_in = $signed(XY_W'(root_y));
			assign z_in = '0;
		end else begin : g_next
			assign x_in = vx_s[i];
			assign y_in = vy_s[i];
			assign z_in = vz_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!y_in[XY_W-1]) begin
					vx_s[i+1] <= x_in + (y_in >>> i);
					vy_s[i+1] <= y_in - (x_in >>> i);
					vz_s[i+1] <= z_in + ATAN_I;
				end else begin
					vx_s[i+1] <= x_in - (y_in >>> i);
					vy_s[i+1] <= y_in + (x_in >>> i);
					vz_s[i+1] <= z_in - ATAN_I;
				end
			end
		end
	end

	// double the angle, clamp, scale
	assign twice = {vz_s[CORDIC_STAGES], 1'b0};

	always_comb begin
		if (vz_s[CORDIC_STAGES][XY_W-1])
			central = '0;
		else if (twice[XY_W:32] != '0)
			central = '1;
		else
			central = twice[31:0];
	end

	assign dsum = 65'(prod_s9) + 65'd536870912;
	assign dq   = dsum[64:30];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s9  <= 64'(central) * 64'(distance_scale_q);
			dist_s10 <= (dq[34:32] != '0) ? '1 : dq[31:0];
		end
	end

endmodule

>>> rtl/gcd_sincos.sv
// ----------------------------------------------------------------------------
// gcd_sincos: pipelined sine and cosine
// Wraps the angle into [-pi, pi], folds it into [-pi/2, pi/2] and runs a
// rotation CORDIC with one iteration per register stage.
// ----------------------------------------------------------------------------
module gcd_sincos #(
	parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [gcd_pkg::ANG_W-1:0]     ang,
	output logic signed [gcd_pkg::XY_W-1:0]      sin_val,
	output logic signed [gcd_pkg::XY_W-1:0]      cos_val
);

	logic signed [gcd_pkg::ANG_W-1:0] wrap;
	logic signed [gcd_pkg::ANG_W-1:0] wrap_s1;
	logic signed [gcd_pkg::ANG_W-1:0] fold;
	logic                             flip;

	logic signed [gcd_pkg::XY_W-1:0] x_s [0:STAGES];
	logic signed [gcd_pkg::XY_W-1:0] y_s [0:STAGES];
	logic signed [gcd_pkg::XY_W-1:0] z_s [0:STAGES];
	logic                            flip_s [0:STAGES];

	// wrap by one full turn
	always_comb begin
		if (ang > gcd_pkg::PI_Q30)
			wrap = ang - gcd_pkg::TWO_PI_Q30;
		else if (ang < -gcd_pkg::PI_Q30)
			wrap = ang + gcd_pkg::TWO_PI_Q30;
		else
			wrap = ang;
	end

	always_ff @(posedge clk) begin
		if (en)
			wrap_s1 <= wrap;
	end

	// fold into the right half plane, remember to negate the cosine
	always_comb begin
		if (wrap_s1 > gcd_pkg::HALF_PI_Q30) begin
			fold = gcd_pkg::PI_Q30 - wrap_s1;
			flip = 1'b1;
		end else if (wrap_s1 < -gcd_pkg::HALF_PI_Q30) begin
			fold = -gcd_pkg::PI_Q30 - wrap_s1;
			flip = 1'b1;
		end else begin
			fold = wrap_s1;
			flip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= gcd_pkg::GAIN_Q30;
			y_s[0]    <= '0;
			z_s[0]    <= fold[gcd_pkg::XY_W-1:0];
			flip_s[0] <= flip;
		end
	end

	// rotation iterations, one per stage
	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		localparam logic signed [gcd_pkg::XY_W-1:0] ATAN_I = gcd_pkg::atan_q30(i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][gcd_pkg::XY_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_I;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_I;
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	assign sin_val = y_s[STAGES];
	assign cos_val = flip_s[STAGES] ? -x_s[STAGES] : x_s[STAGES];

endmodule

>>> rtl/gcd_isqrt.sv
// ----------------------------------------------------------------------------
// gcd_isqrt: pipelined integer square root
// Floor square root of a 62-bit radicand, one root bit per register stage.
// ----------------------------------------------------------------------------
module gcd_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [61:0] radicand,
	output logic [30:0] root
);

	localparam int RAD_W  = 62;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	logic [REM_W-1:0]  rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	logic [RAD_W-1:0]  v_s    [1:ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  v_in;
		logic [REM_W+1:0]  cur;
		logic [REM_W+1:0]  trial;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign v_in    = radicand;
		end else begin : g_next
			assign rem_in  = rem_s[i];
			assign root_in = root_s[i];
			assign v_in    = v_s[i];
		end

		// bring down two radicand bits, try the next root bit
		assign cur   = {rem_in, v_in[RAD_W-1-2*i -: 2]};
		assign trial = (REM_W+2)'({root_in, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					rem_s[i+1]  <= REM_W'(cur - trial);
					root_s[i+1] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[i+1]  <= REM_W'(cur);
					root_s[i+1] <= {root_in[ROOT_W-2:0], 1'b0};
				end
				v_s[i+1] <= v_in;
			end
		end
	end

	assign root = root_s[ROOT_W];

endmodule
